// File: rtl/core/shiprr_pkg.sv
// Shared types and constants for the RRIP replacement engine with reuse
// predictor and stride detector. No dependencies.
package shiprr_pkg;

  localparam int unsigned NUM_SETS_DEF   = 2048;
  localparam int unsigned NUM_WAYS_DEF   = 16;
  localparam int unsigned SIG_BITS_DEF   = 6;
  localparam int unsigned RRPV_WIDTH_DEF = 2;

  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned BADDR_W     = 64 - BLOCK_SHIFT;

  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_RESET = 2'd1;
  localparam logic [1:0] RUN_MAX   = 2'd3;

  localparam logic [1:0] REUSE_THR_RESET  = 2'd1;
  localparam logic [1:0] STREAM_THR_RESET = 2'd3;
  localparam logic [7:0] STRIDE_LIM_RESET = 8'd8;

  typedef enum logic [1:0] {
    CFG_REUSE_THR  = 2'd0,
    CFG_STREAM_THR = 2'd1,
    CFG_STRIDE_LIM = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_VICTIM = 1'b0,
    REQ_UPDATE = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [63:0] paddr;
    logic [63:0] pc;
    logic        hit;
  } req_t;

  typedef struct packed {
    logic [1:0] reuse_thr;
    logic [1:0] stream_thr;
    logic [7:0] stride_lim;
  } cfg_t;

endpackage

// File: rtl/core/shiprr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module shiprr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/shiprr_update.sv
// Read-modify-write datapath for one set row: victim search with aging,
// hit update, stride detection and fill insertion. Depends on shiprr_pkg.
module shiprr_update import shiprr_pkg::*; #(
  parameter int unsigned NUM_SETS   = NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS   = NUM_WAYS_DEF,
  parameter int unsigned SIG_BITS   = SIG_BITS_DEF,
  parameter int unsigned RRPV_WIDTH = RRPV_WIDTH_DEF,
  localparam int unsigned SIG_COUNT = 1 << SIG_BITS,
  localparam int unsigned BLK_W     = 1 + SIG_BITS + RRPV_WIDTH,
  localparam int unsigned CTR_OFS   = NUM_WAYS * BLK_W,
  localparam int unsigned STR_OFS   = CTR_OFS + 2 * SIG_COUNT,
  localparam int unsigned ROW_W     = STR_OFS + 2 * BADDR_W + 3
) (
  input  req_t             req_i,
  input  cfg_t             cfg_i,
  input  logic [ROW_W-1:0] row_i,
  output logic [ROW_W-1:0] row_o,
  output logic             we_o,
  output logic [3:0]       victim_o
);

  localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam logic [RRPV_WIDTH-1:0] RRPV_SAT  = {RRPV_WIDTH{1'b1}};
  localparam logic [RRPV_WIDTH-1:0] RRPV_FAR  = RRPV_SAT - RRPV_WIDTH'(1);
  localparam logic [RRPV_WIDTH-1:0] RRPV_NEAR = '0;

  logic [RRPV_WIDTH-1:0] rrpv [NUM_WAYS];
  logic [SIG_BITS-1:0]   sig  [NUM_WAYS];
  logic                  vld  [NUM_WAYS];
  logic [1:0]            ctr  [SIG_COUNT];
  logic [BADDR_W-1:0]    recent_blk, older_blk, new_addr;
  logic [1:0]            run;
  logic                  strm;
  logic [RRPV_WIDTH-1:0] top, add;
  logic [WAY_W-1:0]      vic_idx, way_idx;
  logic                  found;
  logic [SIG_BITS-1:0]   sig_new, sig_old;
  logic [63:0]           sig_mix;
  logic [BADDR_W:0]      d1, d2;
  logic                  stride_ok;
  logic                  set_ok, way_ok;
  logic [5:0]            way_ext;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv[w] = row_i[w*BLK_W +: RRPV_WIDTH];
      sig[w]  = row_i[w*BLK_W+RRPV_WIDTH +: SIG_BITS];
      vld[w]  = row_i[w*BLK_W+RRPV_WIDTH+SIG_BITS];
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      ctr[s] = row_i[CTR_OFS+2*s +: 2];
    end
    recent_blk = row_i[STR_OFS +: BADDR_W];
    older_blk  = row_i[STR_OFS+BADDR_W +: BADDR_W];
    run        = row_i[STR_OFS+2*BADDR_W +: 2];
    strm       = row_i[STR_OFS+2*BADDR_W+2];

    set_ok  = 17'(req_i.set_index) < 17'(NUM_SETS);
    way_ext = 6'(req_i.way);
    way_ok  = way_ext < 6'(NUM_WAYS);
    way_idx = way_ext[WAY_W-1:0];
    sig_mix = (req_i.pc >> 2) ^ 64'(req_i.set_index);
    sig_new = sig_mix[SIG_BITS-1:0];
    new_addr = req_i.paddr[63:BLOCK_SHIFT];

    // age the set so that at least one way reaches the maximum
    top = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv[w] > top) top = rrpv[w];
    end
    add      = RRPV_SAT - top;
    found    = 1'b0;
    vic_idx  = '0;
    stride_ok = 1'b0;
    d1 = '0;
    d2 = '0;
    sig_old = '0;
    we_o = 1'b0;

    if (req_i.req_type == REQ_VICTIM) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        rrpv[w] = rrpv[w] + add;
        if (!found && rrpv[w] == RRPV_SAT) begin
          found   = 1'b1;
          vic_idx = WAY_W'(w);
        end
      end
      we_o = set_ok;
    end else if (req_i.hit) begin
      rrpv[way_idx] = RRPV_NEAR;
      sig[way_idx]  = sig_new;
      vld[way_idx]  = 1'b1;
      if (ctr[sig_new] < CTR_MAX) ctr[sig_new] = ctr[sig_new] + 2'd1;
      we_o = set_ok && way_ok;
    end else begin
      d1 = {1'b0, new_addr} - {1'b0, recent_blk};
      d2 = {1'b0, recent_blk} - {1'b0, older_blk};
      stride_ok = (older_blk != '0) && (d1 == d2) &&
                  ((&d1) || (!d1[BADDR_W] && d1[BADDR_W-1:0] < BADDR_W'(cfg_i.stride_lim)));
      if (stride_ok) begin
        if (run < RUN_MAX) run = run + 2'd1;
      end else begin
        run = 2'd0;
      end
      strm       = run >= cfg_i.stream_thr;
      older_blk  = recent_blk;
      recent_blk = new_addr;
      // drop confidence for the signature of the block being replaced
      if (vld[way_idx]) begin
        sig_old = sig[way_idx];
        if (ctr[sig_old] > 2'd0) ctr[sig_old] = ctr[sig_old] - 2'd1;
      end
      if (strm || ctr[sig_new] < cfg_i.reuse_thr) rrpv[way_idx] = RRPV_FAR;
      else rrpv[way_idx] = RRPV_NEAR;
      sig[way_idx] = sig_new;
      vld[way_idx] = 1'b1;
      we_o = set_ok && way_ok;
    end

    for (int w = 0; w < NUM_WAYS; w++) begin
      row_o[w*BLK_W +: BLK_W] = {vld[w], sig[w], rrpv[w]};
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      row_o[CTR_OFS+2*s +: 2] = ctr[s];
    end
    row_o[STR_OFS +: BADDR_W]         = recent_blk;
    row_o[STR_OFS+BADDR_W +: BADDR_W] = older_blk;
    row_o[STR_OFS+2*BADDR_W +: 2]     = run;
    row_o[STR_OFS+2*BADDR_W+2]        = strm;

    victim_o = set_ok ? 4'(vic_idx) : 4'd0;
  end

endmodule

// File: rtl/core/ship_rrip_stream_replacement.sv
// RRIP replacement engine with signature reuse predictor and stride detector.
// An accepted request is registered; in the execute state the per-set row read from
// the single-port memory is updated and written back, and for a victim request the
// victim strobe is registered. Busy is high in the execute state, so a new request waits.
// Reset: a clearing pass writes every set row, with busy high.
// Results cannot be stalled. Depends on shiprr_pkg, shiprr_ram, shiprr_update.
module ship_rrip_stream_replacement import shiprr_pkg::*; #(
  parameter int unsigned NUM_SETS   = NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS   = NUM_WAYS_DEF,
  parameter int unsigned SIG_BITS   = SIG_BITS_DEF,
  parameter int unsigned RRPV_WIDTH = RRPV_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic [63:0] paddr_i,
  input  logic [63:0] pc_i,
  input  logic        hit_i,
  output logic        victim_valid_o,
  output logic [3:0]  victim_way_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned SIG_COUNT = 1 << SIG_BITS;
  localparam int unsigned BLK_W     = 1 + SIG_BITS + RRPV_WIDTH;
  localparam int unsigned CTR_OFS   = NUM_WAYS * BLK_W;
  localparam int unsigned STR_OFS   = CTR_OFS + 2 * SIG_COUNT;
  localparam int unsigned ROW_W     = STR_OFS + 2 * BADDR_W + 3;
  localparam int unsigned SET_W     = $clog2(NUM_SETS);
  localparam logic [RRPV_WIDTH-1:0] RRPV_SAT = {RRPV_WIDTH{1'b1}};

  state_e           state_q, state_d;
  logic [SET_W-1:0] clr_q, clr_d;
  req_t             req_q, req_d;
  cfg_t             cfg_q, cfg_d;
  logic             vvalid_q, vvalid_d;
  logic [3:0]       vway_q, vway_d;

  logic [ROW_W-1:0] rd_row, upd_row, clr_row, ram_wdata;
  logic [SET_W-1:0] ram_addr;
  logic             ram_we, upd_we;
  logic [3:0]       upd_victim;
  logic [16:0]      set_in_ext, set_q_ext;
  logic             accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign set_in_ext  = 17'(set_index_i);
  assign set_q_ext   = 17'(req_q.set_index);

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      clr_row[w*BLK_W +: BLK_W] = {1'b0, SIG_BITS'(0), RRPV_SAT};
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      clr_row[CTR_OFS+2*s +: 2] = CTR_RESET;
    end
    clr_row[ROW_W-1:STR_OFS] = '0;
  end

  shiprr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (rd_row)
  );

  shiprr_update #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .SIG_BITS   (SIG_BITS),
    .RRPV_WIDTH (RRPV_WIDTH)
  ) u_update (
    .req_i    (req_q),
    .cfg_i    (cfg_q),
    .row_i    (rd_row),
    .row_o    (upd_row),
    .we_o     (upd_we),
    .victim_o (upd_victim)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == SET_W'(NUM_SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy      = 1'b1;
    clr_d     = clr_q;
    req_d     = req_q;
    vvalid_d  = 1'b0;
    vway_d    = vway_q;
    ram_we    = 1'b0;
    ram_wdata = upd_row;
    ram_addr  = set_q_ext[SET_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = clr_row;
        ram_addr  = clr_q;
        clr_d     = clr_q + SET_W'(1);
      end
      ST_IDLE: begin
        busy     = 1'b0;
        ram_addr = set_in_ext[SET_W-1:0];
        if (accept) begin
          req_d = '{req_type: req_type_i, set_index: set_index_i, way: way_i,
                    paddr: paddr_i, pc: pc_i, hit: hit_i};
        end
      end
      ST_EXEC: begin
        ram_we = upd_we;
        if (req_q.req_type == REQ_VICTIM) begin
          vvalid_d = 1'b1;
          vway_d   = upd_victim;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_REUSE_THR:  cfg_d.reuse_thr  = cfg_data_i[1:0];
        CFG_STREAM_THR: cfg_d.stream_thr = cfg_data_i[1:0];
        CFG_STRIDE_LIM: cfg_d.stride_lim = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      vvalid_q <= 1'b0;
      cfg_q    <= '{reuse_thr: REUSE_THR_RESET, stream_thr: STREAM_THR_RESET,
                    stride_lim: STRIDE_LIM_RESET};
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      vvalid_q <= vvalid_d;
      cfg_q    <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    vway_q <= vway_d;
  end

  assign victim_valid_o = vvalid_q;
  assign victim_way_o   = vway_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted request did not raise busy");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_o |-> $past(state_q == ST_EXEC && req_q.req_type == REQ_VICTIM))
    else $error("victim strobe without a victim request");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_o |=> !victim_valid_o) else $error("victim strobe repeated");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EXEC || state_q == ST_CLEAR))
    else $error("row write outside clear or execute");

endmodule

// File: tb/sv/tb_ship_rrip_stream_replacement.sv
// Self-checking testbench for ship_rrip_stream_replacement: drives victim and
// update commands, predicts victim ways with its own copy of the replacement state.
// Depends on shiprr_pkg and the RTL of the block.
module tb_ship_rrip_stream_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import shiprr_pkg::*;

  localparam int unsigned SETS = 2048;
  localparam int unsigned WAYS = 16;
  localparam int unsigned SIGS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = 1'b0;
  logic [10:0] set_index_i = '0;
  logic [3:0]  way_i = '0;
  logic [63:0] paddr_i = '0;
  logic [63:0] pc_i = '0;
  logic        hit_i = 1'b0;
  logic        victim_valid_o;
  logic [3:0]  victim_way_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  ship_rrip_stream_replacement u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .set_index_i, .way_i, .paddr_i,
    .pc_i, .hit_i, .victim_valid_o, .victim_way_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  // Own copy of the replacement state.
  logic [1:0]  rrpv_q   [SETS*WAYS];
  logic [5:0]  sig_q    [SETS*WAYS];
  logic        valid_q  [SETS*WAYS];
  logic [1:0]  reuse_q  [SETS*SIGS];
  logic [63:0] last_q   [SETS];
  logic [63:0] prev_q   [SETS];
  logic [1:0]  run_q    [SETS];
  logic        stream_q [SETS];
  logic [1:0]  reuse_thr = REUSE_THR_RESET;
  logic [1:0]  stream_thr = STREAM_THR_RESET;
  logic [7:0]  stride_lim = STRIDE_LIM_RESET;

  req_t       pending_cmds[$];
  logic [3:0] victim_ways_due[$];
  int         errors = 0;
  int         cycles = 0;
  bit         no_idle = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic apply_cmd(input req_t r);
    int unsigned base, b, idx, vidx, w;
    logic [1:0] top;
    logic [5:0] sig;
    logic [63:0] addr, d1, d2;
    logic [3:0] vw;
    base = r.set_index * WAYS;
    if (r.req_type == REQ_VICTIM) begin
      top = 0;
      for (w = 0; w < WAYS; w++) if (rrpv_q[base+w] > top) top = rrpv_q[base+w];
      if (top < 2'd3) for (w = 0; w < WAYS; w++) rrpv_q[base+w] += 2'd3 - top;
      vw = 0;
      for (w = WAYS; w > 0; w--) if (rrpv_q[base+w-1] == 2'd3) vw = w - 1;
      victim_ways_due.push_back(vw);
      return;
    end
    b = base + r.way;
    sig = r.pc[7:2] ^ r.set_index[5:0];
    idx = r.set_index * SIGS + sig;
    if (r.hit) begin
      rrpv_q[b] = 0;
      sig_q[b] = sig;
      valid_q[b] = 1'b1;
      if (reuse_q[idx] < CTR_MAX) reuse_q[idx]++;
      return;
    end
    addr = {6'd0, r.paddr[63:6]};
    d1 = addr - last_q[r.set_index];
    d2 = last_q[r.set_index] - prev_q[r.set_index];
    if (prev_q[r.set_index] != 0 && d1 == d2 && (d1 == '1 || d1 < {56'd0, stride_lim})) begin
      if (run_q[r.set_index] < RUN_MAX) run_q[r.set_index]++;
    end else begin
      run_q[r.set_index] = 0;
    end
    stream_q[r.set_index] = run_q[r.set_index] >= stream_thr;
    prev_q[r.set_index] = last_q[r.set_index];
    last_q[r.set_index] = addr;
    if (valid_q[b]) begin
      vidx = r.set_index * SIGS + sig_q[b];
      if (reuse_q[vidx] > 0) reuse_q[vidx]--;
    end
    rrpv_q[b] = (stream_q[r.set_index] || reuse_q[idx] < reuse_thr) ? 2'd2 : 2'd0;
    sig_q[b] = sig;
    valid_q[b] = 1'b1;
  endtask

  // Driver: command transfer when start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_cmd(pending_cmds[0]);
        void'(pending_cmds.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 27)) begin
          start       <= 1'b1;
          req_type_i  <= pending_cmds[0].req_type;
          set_index_i <= pending_cmds[0].set_index;
          way_i       <= pending_cmds[0].way;
          paddr_i     <= pending_cmds[0].paddr;
          pc_i        <= pending_cmds[0].pc;
          hit_i       <= pending_cmds[0].hit;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: one victim strobe per victim request, in order.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ship_rrip_stream_replacement NOT OK");
      $finish;
    end
    if (rst_ni && victim_valid_o) begin
      if (victim_ways_due.size() == 0) begin
        $error("victim_way: unexpected result %0d", victim_way_o);
        errors++;
      end else begin
        if (victim_way_o !== victim_ways_due[0]) begin
          $error("victim_way: expected %0d actual %0d", victim_ways_due[0], victim_way_o);
          errors++;
        end
        void'(victim_ways_due.pop_front());
      end
    end
  end

  function automatic req_t make_cmd(logic kind, logic [10:0] s, logic [3:0] w,
                                    logic [63:0] pa, logic [63:0] p, logic h);
    req_t r;
    r.req_type = kind;
    r.set_index = s;
    r.way = w;
    r.paddr = pa;
    r.pc = p;
    r.hit = h;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || victim_ways_due.size() != 0);
    // updates give no strobe: let the last one drain
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e i, logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i;
    cfg_data_i  <= d;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (i)
      CFG_REUSE_THR:  reuse_thr = d[1:0];
      CFG_STREAM_THR: stream_thr = d[1:0];
      CFG_STRIDE_LIM: stride_lim = d;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_random(int n);
    int cnt, len, k;
    logic [10:0] s;
    logic [63:0] blk, stride, pcv;
    cnt = 0;
    while (cnt < n) begin
      s = $urandom_range(0, 3) * 509;
      pcv = {$urandom_range(0, 7), 2'b00} ^ ({56'd0, $urandom_range(0, 1), 7'd0});
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          blk = {6'd0, rand64() >> 6};
          case ($urandom_range(0, 3))
            0: stride = '1;
            1: stride = $urandom_range(0, 300);
            default: stride = $urandom_range(1, 8);
          endcase
          len = $urandom_range(3, 6);
          for (k = 0; k < len; k++) begin
            pending_cmds.push_back(make_cmd(REQ_UPDATE, s, $urandom_range(0, 15),
                                            {blk[57:0], 6'($urandom_range(0, 63))},
                                            pcv, 1'b0));
            blk = blk + stride;
          end
          pending_cmds.push_back(make_cmd(REQ_VICTIM, s, 0, 0, 0, 0));
          cnt += len + 1;
        end
        4, 5, 6, 7: begin
          pending_cmds.push_back(make_cmd($urandom_range(0, 1), s, $urandom_range(0, 15),
                                          rand64(), pcv, $urandom_range(0, 1)));
          cnt++;
        end
        default: begin
          pending_cmds.push_back(make_cmd($urandom_range(0, 1), $urandom_range(0, 2047),
                                          $urandom_range(0, 15), rand64(), rand64(),
                                          $urandom_range(0, 1)));
          cnt++;
        end
      endcase
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < SETS*WAYS; i++) begin
      rrpv_q[i] = 2'd3;
      sig_q[i] = 0;
      valid_q[i] = 0;
    end
    for (i = 0; i < SETS*SIGS; i++) reuse_q[i] = CTR_RESET;
    for (i = 0; i < SETS; i++) begin
      last_q[i] = 0;
      prev_q[i] = 0;
      run_q[i] = 0;
      stream_q[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty set, extremes, hit/fill, forward and backward strides.
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 2047, 15, '1, '1, 1));
    pending_cmds.push_back(make_cmd(REQ_UPDATE, 2047, 15, '1, '1, 1));
    pending_cmds.push_back(make_cmd(REQ_UPDATE, 2047, 0, '1, '1, 0));
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 2047, 0, 0, 0, 0));
    for (i = 1; i <= 5; i++)
      pending_cmds.push_back(make_cmd(REQ_UPDATE, 5, i, 64'h1000 + 64*i, 64'h40, 0));
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 5, 0, 0, 0, 0));
    for (i = 0; i < 5; i++)
      pending_cmds.push_back(make_cmd(REQ_UPDATE, 6, 15 - i, 64'h8000 - 64*i, 64'h0, 0));
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 6, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(REQ_UPDATE, 6, 3, 0, 64'h0, 1));
    pending_cmds.push_back(make_cmd(REQ_UPDATE, 6, 3, 64'h100, 64'h0, 0));
    pending_cmds.push_back(make_cmd(REQ_VICTIM, 6, 0, 0, 0, 0));
    load_random(150);
    wait_quiet();

    write_reg(CFG_REUSE_THR, 8'd0);
    write_reg(CFG_STREAM_THR, 8'd0);
    write_reg(CFG_STRIDE_LIM, 8'd0);
    load_random(150);
    wait_quiet();

    write_reg(CFG_REUSE_THR, 8'hff);
    write_reg(CFG_STREAM_THR, 8'hff);
    write_reg(CFG_STRIDE_LIM, 8'hff);
    write_reg(cfg_idx_e'(2'd3), 8'h5a);
    no_idle = 1'b1;
    load_random(200);
    wait_quiet();
    no_idle = 1'b0;

    write_reg(CFG_REUSE_THR, 8'd2);
    write_reg(CFG_STREAM_THR, 8'd1);
    write_reg(CFG_STRIDE_LIM, 8'd3);
    load_random(180);
    wait_quiet();

    if (errors == 0) begin
      $display("tb_ship_rrip_stream_replacement OK");
    end else begin
      $display("tb_ship_rrip_stream_replacement NOT OK");
    end
    $finish;
  end
endmodule
